// ===== sv/mied_pkg.sv =====
package mied_pkg;

	// raw lines and output masks are fixed at six channels
	localparam int unsigned LINES = 6;
	localparam int unsigned OUT_BITS = 6;
	localparam int unsigned TIME_W = 8;
	localparam int unsigned CFG_IDX_W = 3;

	// bit position of each channel in the masks
	localparam int unsigned CH_POWER = 0;
	localparam int unsigned CH_ADAPTER = 1;
	localparam int unsigned CH_BATTERY = 2;
	localparam int unsigned CH_LID = 3;
	localparam int unsigned CH_SECOND = 4;
	localparam int unsigned CH_NET_WAKE = 5;

	localparam logic [TIME_W-1:0] TIME_RESET = 8'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POWER_BUTTON_TIME  = 3'd0,
		CFG_ADAPTER_TIME       = 3'd1,
		CFG_BATTERY_TIME       = 3'd2,
		CFG_LID_TIME           = 3'd3,
		CFG_SECOND_BUTTON_TIME = 3'd4,
		CFG_NET_WAKE_TIME      = 3'd5,
		CFG_NET_WAKE_ENABLE    = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic rise;
		logic fall;
		logic stable;
	} lane_status_t;

endpackage

// ===== sv/multi_input_event_debouncer_core.sv =====
// Six-channel switch debouncer (power button, adapter, battery, lid closed,
// second button, LAN wake). One tick is taken every clock cycle while in_valid
// and in_ready are both high, and its result is loaded into the output register
// at that transfer. Input ready only drops while that register is full and not taken. Each
// channel has its own lane with a down counter, updated once per tick, so a
// level change is accepted on the (T+1)-th consecutive differing tick where T
// is that channel's time register; a time of zero never fires. The lid level
// is the inverted lid switch, the power level reads released while both
// buttons are held, and the LAN wake level is forced low when its enable is 0.
// Registers are written through the configuration channel, which is always
// ready; write them only while no tick is in flight.
module multi_input_event_debouncer_core #(
	parameter int unsigned CHANNELS = 6,
	parameter int unsigned COUNT_WIDTH = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mied_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mied_pkg::TIME_W-1:0]           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  power_button_raw,
	input  logic                                  adapter_raw,
	input  logic                                  battery_raw,
	input  logic                                  lid_switch_raw,
	input  logic                                  second_button_raw,
	input  logic                                  net_wake_raw,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [mied_pkg::OUT_BITS-1:0]         press_mask,
	output logic [mied_pkg::OUT_BITS-1:0]         release_mask,
	output logic [mied_pkg::OUT_BITS-1:0]         stable_levels
);

	logic [mied_pkg::TIME_W-1:0] time_q [mied_pkg::LINES];
	logic                        lan_enable_q;
	logic [mied_pkg::LINES-1:0]  line_level;
	logic                        step;
	logic                        accept_ok;
	mied_pkg::lane_status_t      status [CHANNELS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mied_pkg::LINES; i++) begin
				time_q[i] <= mied_pkg::TIME_RESET;
			end
			lan_enable_q <= 1'b1;
		end else if (cfg_valid) begin
			case (mied_pkg::cfg_idx_t'(cfg_index))
				mied_pkg::CFG_POWER_BUTTON_TIME: begin
					time_q[mied_pkg::CH_POWER] <= cfg_data;
				end
				mied_pkg::CFG_ADAPTER_TIME: begin
					time_q[mied_pkg::CH_ADAPTER] <= cfg_data;
				end
				mied_pkg::CFG_BATTERY_TIME: begin
					time_q[mied_pkg::CH_BATTERY] <= cfg_data;
				end
				mied_pkg::CFG_LID_TIME: begin
					time_q[mied_pkg::CH_LID] <= cfg_data;
				end
				mied_pkg::CFG_SECOND_BUTTON_TIME: begin
					time_q[mied_pkg::CH_SECOND] <= cfg_data;
				end
				mied_pkg::CFG_NET_WAKE_TIME: begin
					time_q[mied_pkg::CH_NET_WAKE] <= cfg_data;
				end
				mied_pkg::CFG_NET_WAKE_ENABLE: begin
					lan_enable_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		line_level[mied_pkg::CH_POWER] = power_button_raw & ~second_button_raw;
		line_level[mied_pkg::CH_ADAPTER] = adapter_raw;
		line_level[mied_pkg::CH_BATTERY] = battery_raw;
		line_level[mied_pkg::CH_LID] = ~lid_switch_raw;
		line_level[mied_pkg::CH_SECOND] = second_button_raw;
		line_level[mied_pkg::CH_NET_WAKE] = net_wake_raw & lan_enable_q;
	end

	assign in_ready = accept_ok;
	assign step = in_valid & accept_ok;

	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		logic                   lane_level;
		logic [COUNT_WIDTH-1:0] lane_time;

		// lanes past the six lines see level 0 and time 0
		if (i < mied_pkg::LINES) begin : g_line
			assign lane_level = line_level[i];
			assign lane_time = COUNT_WIDTH'(time_q[i]);
		end else begin : g_spare
			assign lane_level = 1'b0;
			assign lane_time = '0;
		end

		mied_lane #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.step(step),
			.level(lane_level),
			.load_time(lane_time),
			.status(status[i])
		);
	end

	mied_merge #(
		.CHANNELS(CHANNELS)
	) u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.status(status),
		.accept_ok(accept_ok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.press_mask(press_mask),
		.release_mask(release_mask),
		.stable_levels(stable_levels)
	);

endmodule

// ===== sv/mied_lane.sv =====
module mied_lane #(
	parameter int unsigned COUNT_WIDTH = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   level,
	input  logic [COUNT_WIDTH-1:0] load_time,
	output mied_pkg::lane_status_t status
);

	logic [COUNT_WIDTH-1:0] count_q;
	logic                   stable_q;
	logic                   differ;
	logic                   count_zero;
	logic                   fire;

	assign differ = level ^ stable_q;
	assign count_zero = (count_q == '0);
	// counter at one means this differing tick takes it to zero
	assign fire = step & differ & (count_q == COUNT_WIDTH'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			stable_q <= 1'b0;
		end else if (step) begin
			if (!differ) begin
				count_q <= '0;
			end else if (count_zero) begin
				count_q <= load_time;
			end else begin
				count_q <= count_q - COUNT_WIDTH'(1);
			end
			if (fire) begin
				stable_q <= level;
			end
		end
	end

	always_comb begin
		status.rise = fire & level;
		status.fall = fire & ~level;
		status.stable = fire ? level : stable_q;
	end

endmodule

// ===== sv/mied_merge.sv =====
module mied_merge #(
	parameter int unsigned CHANNELS = 6
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  step,
	input  mied_pkg::lane_status_t                status [CHANNELS],
	output logic                                  accept_ok,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [mied_pkg::OUT_BITS-1:0]         press_mask,
	output logic [mied_pkg::OUT_BITS-1:0]         release_mask,
	output logic [mied_pkg::OUT_BITS-1:0]         stable_levels
);

	logic                            out_valid_q;
	logic [mied_pkg::OUT_BITS-1:0]   press_q;
	logic [mied_pkg::OUT_BITS-1:0]   release_q;
	logic [mied_pkg::OUT_BITS-1:0]   stable_q;
	logic [mied_pkg::OUT_BITS-1:0]   rise_w;
	logic [mied_pkg::OUT_BITS-1:0]   fall_w;
	logic [mied_pkg::OUT_BITS-1:0]   stable_w;

	// mask bits past the lane count are fed zero rather than any lane's status
	for (genvar i = 0; i < mied_pkg::OUT_BITS; i++) begin : g_bits
		if (i < CHANNELS) begin : g_lane
			assign rise_w[i] = status[i].rise;
			assign fall_w[i] = status[i].fall;
			assign stable_w[i] = status[i].stable;
		end else begin : g_none
			assign rise_w[i] = 1'b0;
			assign fall_w[i] = 1'b0;
			assign stable_w[i] = 1'b0;
		end
	end

	assign accept_ok = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept_ok) begin
			out_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			press_q <= rise_w;
			release_q <= fall_w;
			stable_q <= stable_w;
		end
	end

	assign out_valid = out_valid_q;
	assign press_mask = press_q;
	assign release_mask = release_q;
	assign stable_levels = stable_q;

`ifndef SYNTH
	a_press_release_apart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((press_q & release_q) == '0))
		else $error("press and release flagged on the same channel");

	a_press_sets_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((press_q & ~stable_q) == '0))
		else $error("press flagged but stable level is low");

	a_release_clears_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((release_q & stable_q) == '0))
		else $error("release flagged but stable level is high");

	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("transfer in gave no result");
`endif

endmodule
